// File: rtl/core/dcc_instruction_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// dcc_instruction_encoder_unit_macros
// Assertion macros for the DCC instruction encoder unit.
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DCC_INSTRUCTION_ENCODER_UNIT_MACROS_SVH
`define DCC_INSTRUCTION_ENCODER_UNIT_MACROS_SVH

// Check a condition that must hold in the same cycle as its trigger.
`define DCCIE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dccie same-cycle check failed");

// Check a condition that must hold in the cycle after its trigger.
`define DCCIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dccie next-cycle check failed");

`endif

// File: rtl/core/dccie_pkg.sv
// ----------------------------------------------------------------------------
// dccie_pkg
// Shared types and constants of the DCC instruction encoder: command classes,
// step modes, queue entry and result word layouts, instruction byte codes.
// ----------------------------------------------------------------------------
package dccie_pkg;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input function codes
  typedef enum logic [3:0] {
    FN_SPEED   = 4'd0,
    FN_FG1     = 4'd1,
    FN_FG2     = 4'd2,
    FN_FG3     = 4'd3,
    FN_FG_ALL  = 4'd4,
    FN_CV      = 4'd5,
    FN_STOP    = 4'd6,
    FN_ACC_SET = 4'd7,
    FN_ACC_CLR = 4'd8
  } func_t;

  // Classified command, as carried in the queue
  typedef enum logic [3:0] {
    CMD_REJECT,
    CMD_SPEED,
    CMD_ESTOP,
    CMD_FG1,
    CMD_FG2,
    CMD_FG3,
    CMD_FG_ALL,
    CMD_CV,
    CMD_ACC
  } cmd_t;

  typedef enum logic [1:0] {
    STEP_14,
    STEP_28,
    STEP_128
  } step_mode_t;

  // Queue classes
  localparam logic [1:0] QC_EMERGENCY = 2'd0;
  localparam logic [1:0] QC_HIGH      = 2'd1;
  localparam logic [1:0] QC_LOW       = 2'd2;

  // Packet kinds
  localparam logic [2:0] PK_SPEED  = 3'd0;
  localparam logic [2:0] PK_FG1    = 3'd1;
  localparam logic [2:0] PK_FG2    = 3'd2;
  localparam logic [2:0] PK_FG3    = 3'd3;
  localparam logic [2:0] PK_CV     = 3'd4;
  localparam logic [2:0] PK_ESTOP  = 3'd5;
  localparam logic [2:0] PK_ACC    = 3'd6;

  // Repeat counts
  localparam logic [3:0] REP_NORMAL = 4'd3;
  localparam logic [3:0] REP_ESTOP  = 4'd10;
  localparam logic [3:0] REP_ACC    = 4'd2;

  // Supported step counts
  localparam logic [7:0] STEPS_14  = 8'd14;
  localparam logic [7:0] STEPS_28  = 8'd28;
  localparam logic [7:0] STEPS_128 = 8'd128;
  localparam logic [7:0] STEPS_RESET = 8'd128;

  // Instruction byte codes
  localparam logic [7:0] BYTE_SPEED    = 8'h40;
  localparam logic [7:0] BYTE_ADV_SPD  = 8'h3F;
  localparam logic [7:0] BYTE_DIR_1428 = 8'h20;
  localparam logic [7:0] BYTE_DIR_128  = 8'h80;
  localparam logic [7:0] BYTE_FG1      = 8'h80;
  localparam logic [7:0] BYTE_FG2      = 8'hB0;
  localparam logic [7:0] BYTE_FG3      = 8'hA0;
  localparam logic [7:0] BYTE_CV_WRITE = 8'hEC;
  localparam logic [7:0] BYTE_ESTOP    = 8'h41;
  localparam logic [6:0] SPEED_MAX     = 7'd127;

  // Step scaling: floor(x*13/125) and floor(x*29/125) for x <= 125 as
  // x * (k * ceil(2^20/125)) >> 20, exact over that range.
  localparam int          SCALE_SHIFT = 20;
  localparam logic [23:0] MUL_14      = 24'd109057;
  localparam logic [24:0] MUL_28      = 25'd243281;

  typedef struct packed {
    cmd_t        cmd;
    step_mode_t  step;
    logic        dir;
    logic [6:0]  mag;
    logic [13:0] address;
    logic        long_address;
    logic [12:0] function_bits;
    logic [9:0]  cv_index;
    logic [7:0]  cv_value;
    logic [1:0]  acc_output;
    logic        acc_set;
  } cmd_entry_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  queue_class;
    logic [2:0]  packet_kind;
    logic [3:0]  repeat_count;
    logic [13:0] address;
    logic        long_address;
    logic [1:0]  byte_count;
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [7:0]  byte_third;
    logic        last;
  } result_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// File: rtl/core/dcc_instruction_encoder_unit.sv
// ----------------------------------------------------------------------------
// dcc_instruction_encoder_unit
// Encodes model-railway commands into DCC instruction bytes with packet kind,
// repeat count and queue class.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through a queue-style port: a word is taken at a clock
//   edge with push high and full low. Results leave the same way: while empty
//   is low the oldest result is on the out_ ports, and pop takes it.
//   cfg_we/cfg_wdata write the default step count used when a speed command
//   gives zero steps; write it only while no command is in flight.
//   A command passes through the command queue and then the result register
//   on its way to the out_ ports. A new command is taken every cycle while
//   the two-entry command queue has room. The encoder stage gives one result
//   word per cycle while the result register is free or being popped; an
//   all-functions command gives three words.
//   If the receiver stalls, the result register holds its word, the command
//   queue fills and full rises after two more commands.
//   Reset (rst_n low at a clock edge) empties the queue and result register
//   and sets the default step count to 128.
// ----------------------------------------------------------------------------
`include "dcc_instruction_encoder_unit_macros.svh"

module dcc_instruction_encoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         in_func,
  input  logic [13:0]        in_address,
  input  logic               in_long_address,
  input  logic signed [7:0]  in_speed,
  input  logic [7:0]         in_speed_steps,
  input  logic [12:0]        in_function_bits,
  input  logic [10:0]        in_cv_number,
  input  logic [7:0]         in_cv_value,
  input  logic [1:0]         in_accessory_output,
  output logic               empty,
  input  logic               pop,
  output logic               out_accepted,
  output logic [1:0]         out_queue_class,
  output logic [2:0]         out_packet_kind,
  output logic [3:0]         out_repeat_count,
  output logic [13:0]        out_address,
  output logic               out_long_address,
  output logic [1:0]         out_byte_count,
  output logic [7:0]         out_byte_first,
  output logic [7:0]         out_byte_second,
  output logic [7:0]         out_byte_third,
  output logic               out_last
);
  import dccie_pkg::*;

  cmd_entry_t q_wdata;
  cmd_entry_t q_head;
  q_status_t  q_stat;
  logic       q_wr;
  logic       q_rd;
  result_t    res;
  logic       res_valid;

  // Accept and classify commands
  dccie_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .push                (push),
    .full                (full),
    .in_func             (in_func),
    .in_address          (in_address),
    .in_long_address     (in_long_address),
    .in_speed            (in_speed),
    .in_speed_steps      (in_speed_steps),
    .in_function_bits    (in_function_bits),
    .in_cv_number        (in_cv_number),
    .in_cv_value         (in_cv_value),
    .in_accessory_output (in_accessory_output),
    .q_stat              (q_stat),
    .q_wr                (q_wr),
    .q_wdata             (q_wdata)
  );

  // Buffer classified commands
  dccie_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_head),
    .stat  (q_stat)
  );

  // Encode and hold results
  dccie_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_rd      (q_rd),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty            = !res_valid;
  assign out_accepted     = res.accepted;
  assign out_queue_class  = res.queue_class;
  assign out_packet_kind  = res.packet_kind;
  assign out_repeat_count = res.repeat_count;
  assign out_address      = res.address;
  assign out_long_address = res.long_address;
  assign out_byte_count   = res.byte_count;
  assign out_byte_first   = res.byte_first;
  assign out_byte_second  = res.byte_second;
  assign out_byte_third   = res.byte_third;
  assign out_last         = res.last;

  // A rejected command gives one bare, final word
  `DCCIE_ASSERT_NOW(a_reject_final, !empty && !out_accepted, out_last && (out_byte_count == 2'd0))
  // A non-final group word means its command still sits at the queue head
  `DCCIE_ASSERT_NOW(a_group_held, !empty && !out_last, !q_stat.empty)
  // Queue fill never passes its depth
  `DCCIE_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH))
  // A taken command never leaves the queue empty in the next cycle
  `DCCIE_ASSERT_NEXT(a_push_lands, push && !full && !q_rd, !q_stat.empty)

endmodule

// File: rtl/core/dccie_front.sv
// ----------------------------------------------------------------------------
// dccie_front
// Accepts commands, resolves the step mode against the default-steps
// register and classifies each command into a queue entry.
// ----------------------------------------------------------------------------
module dccie_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,
  input  logic                   push,
  output logic                   full,
  input  logic [3:0]             in_func,
  input  logic [13:0]            in_address,
  input  logic                   in_long_address,
  input  logic signed [7:0]      in_speed,
  input  logic [7:0]             in_speed_steps,
  input  logic [12:0]            in_function_bits,
  input  logic [10:0]            in_cv_number,
  input  logic [7:0]             in_cv_value,
  input  logic [1:0]             in_accessory_output,
  input  dccie_pkg::q_status_t   q_stat,
  output logic                   q_wr,
  output dccie_pkg::cmd_entry_t  q_wdata
);
  import dccie_pkg::*;

  logic [7:0] default_steps_r;
  logic [7:0] steps;
  logic       steps_ok;
  step_mode_t step_mode;
  logic       neg;
  logic [7:0] mag_full;
  logic [6:0] mag;

  // Hold the default step count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_steps_r <= STEPS_RESET;
    end else if (cfg_we) begin
      default_steps_r <= cfg_wdata;
    end
  end

  // Resolve step count and speed magnitude
  always_comb begin
    steps     = (in_speed_steps != 8'd0) ? in_speed_steps : default_steps_r;
    steps_ok  = 1'b1;
    step_mode = STEP_128;
    case (steps)
      STEPS_14:  step_mode = STEP_14;
      STEPS_28:  step_mode = STEP_28;
      STEPS_128: step_mode = STEP_128;
      default:   steps_ok  = 1'b0;
    endcase
    neg      = in_speed[7];
    mag_full = neg ? 8'(-in_speed) : 8'(in_speed);
    mag      = mag_full[7] ? SPEED_MAX : mag_full[6:0];
  end

  // Classify the command
  always_comb begin
    q_wdata               = '0;
    q_wdata.cmd           = CMD_REJECT;
    q_wdata.step          = step_mode;
    q_wdata.dir           = ~neg;
    q_wdata.mag           = mag;
    q_wdata.address       = in_address;
    q_wdata.long_address  = in_long_address;
    q_wdata.function_bits = in_function_bits;
    q_wdata.cv_index      = 10'(in_cv_number - 11'd1);
    q_wdata.cv_value      = in_cv_value;
    q_wdata.acc_output    = in_accessory_output;
    q_wdata.acc_set       = 1'b0;
    unique case (in_func)
      FN_SPEED: begin
        if (!steps_ok) begin
          q_wdata.cmd = CMD_REJECT;
        end else if (mag == 7'd0) begin
          q_wdata.cmd = CMD_ESTOP;
        end else begin
          q_wdata.cmd = CMD_SPEED;
        end
      end
      FN_FG1:     q_wdata.cmd = CMD_FG1;
      FN_FG2:     q_wdata.cmd = CMD_FG2;
      FN_FG3:     q_wdata.cmd = CMD_FG3;
      FN_FG_ALL:  q_wdata.cmd = CMD_FG_ALL;
      FN_CV:      q_wdata.cmd = CMD_CV;
      FN_STOP:    q_wdata.cmd = CMD_ESTOP;
      FN_ACC_SET: begin
        q_wdata.cmd     = CMD_ACC;
        q_wdata.acc_set = 1'b1;
      end
      FN_ACC_CLR: q_wdata.cmd = CMD_ACC;
      default:    q_wdata.cmd = CMD_REJECT;
    endcase
  end

  assign full = q_stat.full;
  assign q_wr = push && !q_stat.full;

endmodule

// File: rtl/core/dccie_queue.sv
// ----------------------------------------------------------------------------
// dccie_queue
// Short command queue between front and back; write and read can happen in the same cycle.
// ----------------------------------------------------------------------------
module dccie_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr,
  input  dccie_pkg::cmd_entry_t  wdata,
  input  logic                   rd,
  output dccie_pkg::cmd_entry_t  rdata,
  output dccie_pkg::q_status_t   stat
);
  import dccie_pkg::*;

  cmd_entry_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_wr;
  logic              do_rd;

  // Advance pointers and count
  always_comb begin
    do_wr      = wr && (count_r != QCNT_W'(QUEUE_DEPTH));
    do_rd      = rd && (count_r != '0);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = entry_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.count = count_r;

endmodule

// File: rtl/core/dccie_back.sv
// ----------------------------------------------------------------------------
// dccie_back
// Encodes the queue head into instruction bytes, steps through the three
// groups of an all-functions command and holds the result register.
// ----------------------------------------------------------------------------
module dccie_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dccie_pkg::cmd_entry_t  head,
  input  dccie_pkg::q_status_t   q_stat,
  output logic                   q_rd,
  output dccie_pkg::result_t     res,
  output logic                   res_valid,
  input  logic                   res_pop
);
  import dccie_pkg::*;

  logic [1:0]  grp_r;
  logic [1:0]  grp_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  result_t     out_r;
  result_t     enc;
  logic        issue;
  logic [6:0]  x;
  logic [23:0] prod14;
  logic [24:0] prod28;
  logic [3:0]  v14;
  logic [4:0]  v28;
  logic [7:0]  spd;
  logic [1:0]  grp;
  logic [4:0]  gbits;
  logic [7:0]  gbyte;

  // Scale speed magnitude into 14 and 28 step codes
  always_comb begin
    x      = head.mag - 7'd2;
    prod14 = 24'(x) * MUL_14;
    prod28 = 25'(x) * MUL_28;
    v14    = 4'(prod14 >> SCALE_SHIFT) + 4'd2;
    v28    = 5'(prod28 >> SCALE_SHIFT) + 5'd2;
    if (head.mag == 7'd1) begin
      spd = BYTE_SPEED;
    end else if (head.step == STEP_14) begin
      spd = BYTE_SPEED | {4'd0, v14};
    end else begin
      spd = BYTE_SPEED | {3'd0, v28[0], v28[4:1]};
    end
    if (head.dir) begin
      spd = spd | BYTE_DIR_1428;
    end
  end

  // Pick the function group and its bits
  always_comb begin
    grp   = 2'd1;
    gbits = head.function_bits[4:0];
    case (head.cmd)
      CMD_FG2: begin
        grp   = 2'd2;
        gbits = {1'b0, head.function_bits[3:0]};
      end
      CMD_FG3: begin
        grp   = 2'd3;
        gbits = {1'b0, head.function_bits[3:0]};
      end
      CMD_FG_ALL: begin
        case (grp_r)
          2'd1: begin
            grp   = 2'd2;
            gbits = {1'b0, head.function_bits[8:5]};
          end
          2'd2: begin
            grp   = 2'd3;
            gbits = {1'b0, head.function_bits[12:9]};
          end
          default: begin
            grp   = 2'd1;
            gbits = head.function_bits[4:0];
          end
        endcase
      end
      default: begin
        grp   = 2'd1;
        gbits = head.function_bits[4:0];
      end
    endcase
    case (grp)
      2'd2:    gbyte = BYTE_FG2 | {4'd0, gbits[3:0]};
      2'd3:    gbyte = BYTE_FG3 | {4'd0, gbits[3:0]};
      default: gbyte = BYTE_FG1 | {3'd0, gbits[0], gbits[4:1]};
    endcase
  end

  // Build the result word
  always_comb begin
    enc              = '0;
    enc.accepted     = 1'b1;
    enc.address      = head.address;
    enc.long_address = head.long_address;
    enc.last         = 1'b1;
    unique case (head.cmd) inside
      CMD_SPEED: begin
        enc.queue_class  = QC_HIGH;
        enc.packet_kind  = PK_SPEED;
        enc.repeat_count = REP_NORMAL;
        if (head.step == STEP_128) begin
          enc.byte_count  = 2'd2;
          enc.byte_first  = BYTE_ADV_SPD;
          enc.byte_second = ((head.mag == 7'd1) ? 8'd0 : {1'b0, head.mag})
                            | (head.dir ? BYTE_DIR_128 : 8'd0);
        end else begin
          enc.byte_count = 2'd1;
          enc.byte_first = spd;
        end
      end
      CMD_ESTOP: begin
        enc.queue_class  = QC_EMERGENCY;
        enc.packet_kind  = PK_ESTOP;
        enc.repeat_count = REP_ESTOP;
        enc.byte_count   = 2'd1;
        enc.byte_first   = BYTE_ESTOP;
      end
      CMD_FG1, CMD_FG2, CMD_FG3, CMD_FG_ALL: begin
        enc.queue_class  = QC_LOW;
        enc.packet_kind  = (grp == 2'd2) ? PK_FG2 : ((grp == 2'd3) ? PK_FG3 : PK_FG1);
        enc.repeat_count = REP_NORMAL;
        enc.byte_count   = 2'd1;
        enc.byte_first   = gbyte;
        enc.last         = (head.cmd != CMD_FG_ALL) || (grp_r == 2'd2);
      end
      CMD_CV: begin
        enc.queue_class  = QC_LOW;
        enc.packet_kind  = PK_CV;
        enc.repeat_count = REP_NORMAL;
        enc.byte_count   = 2'd3;
        enc.byte_first   = BYTE_CV_WRITE | {6'd0, head.cv_index[9:8]};
        enc.byte_second  = head.cv_index[7:0];
        enc.byte_third   = head.cv_value;
      end
      CMD_ACC: begin
        enc.queue_class  = QC_LOW;
        enc.packet_kind  = PK_ACC;
        enc.repeat_count = REP_ACC;
        enc.long_address = 1'b0;
        enc.byte_count   = 2'd1;
        enc.byte_first   = {5'd0, head.acc_output, head.acc_set};
      end
      default: begin
        enc.accepted = 1'b0;
      end
    endcase
  end

  // Issue when the result register is free or being drained
  always_comb begin
    issue         = !q_stat.empty && (!out_valid_r || res_pop);
    q_rd          = issue && enc.last;
    grp_nxt       = grp_r;
    out_valid_nxt = out_valid_r;
    if (issue) begin
      grp_nxt       = enc.last ? 2'd0 : grp_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (res_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (issue) begin
      out_r <= enc;
    end
  end

  assign res       = out_r;
  assign res_valid = out_valid_r;

endmodule
